// ----- hdl/sorted_table_equal_range_search_unit_assert.svh -----
// assertion macros shared by the checker
`ifndef SORTED_TABLE_EQUAL_RANGE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_EQUAL_RANGE_SEARCH_UNIT_ASSERT_SVH

// same-cycle implication
`define STERS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define STERS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sters_pkg.sv -----
`timescale 1ns / 1ps

package sters_pkg;

	localparam int ADDR_W      = 10;
	localparam int TABLE_DEPTH = 1 << ADDR_W;
	localparam int DATA_W      = 32;
	localparam int CNT_W       = ADDR_W + 1;
	// search bounds: one bit for lo past the top, one sign bit for hi below zero
	localparam int PTR_W       = ADDR_W + 2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic REG_RANGE_FIRST = 1'b0;
	localparam logic REG_RANGE_LAST  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_PROBE,
		ST_DONE
	} state_t;

endpackage

// ----- hdl/sorted_table_equal_range_search_unit.sv -----
`timescale 1ns / 1ps

// Equal-range search over a sorted table of 1024 signed 32-bit entries. Software
// loads the table one load item per entry, in ascending order, and sets the index
// window with range_first / range_last through the configuration port (only while
// the block is idle). A query item runs two binary searches over the window, one
// for the leftmost and one for the rightmost entry equal to search_key, and gives
// one result item: found, both positions and match_count. When the key is absent,
// the window is empty or the table turns out unsorted, all result fields are zero.
// Load items give no result. A query takes a setup step per search, then its
// probes, then a final step to register the result; the single read port of the
// table memory sets the probe rate, one probe a cycle. The block stalls its input
// from the query until the result is registered. A finished result is held in an
// output register, so a waiting consumer only holds up the next query at its
// final step. Reading an entry that was never loaded gives undefined results.
module sorted_table_equal_range_search_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// query / load channel
	input  logic                              query_valid,
	output logic                              query_stall,
	input  logic                              operation,
	input  logic [sters_pkg::ADDR_W-1:0]      entry_index,
	input  logic signed [sters_pkg::DATA_W-1:0] entry_value,
	input  logic signed [sters_pkg::DATA_W-1:0] search_key,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              found,
	output logic [sters_pkg::ADDR_W-1:0]      first_position,
	output logic [sters_pkg::ADDR_W-1:0]      last_position,
	output logic [sters_pkg::CNT_W-1:0]       match_count,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic                              cfg_index,
	input  logic [sters_pkg::ADDR_W-1:0]      cfg_data
);

	localparam int AW = sters_pkg::ADDR_W;
	localparam int PW = sters_pkg::PTR_W;
	localparam int DW = sters_pkg::DATA_W;
	localparam int CW = sters_pkg::CNT_W;

	// table memory, one write and one registered read per cycle
	logic signed [DW-1:0] table_mem [sters_pkg::TABLE_DEPTH];
	logic signed [DW-1:0] rd_data_q;
	logic [AW-1:0]        rd_addr;

	// configuration
	logic [AW-1:0] range_first_q;
	logic [AW-1:0] range_last_q;

	// sequencer
	sters_pkg::state_t state_q, state_d;

	// search datapath
	logic signed [DW-1:0] key_q, key_d;
	logic signed [PW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic [AW-1:0]        mid_q, mid_d;
	logic                 seek_right_q, seek_right_d;
	logic                 hit_q, hit_d;
	logic [AW-1:0]        hit_pos_q, hit_pos_d;
	logic                 first_ok_q, first_ok_d;
	logic [AW-1:0]        first_pos_q, first_pos_d;

	// result register
	logic          res_valid_q, res_valid_d;
	logic          res_found_q, res_found_d;
	logic [AW-1:0] res_first_q, res_first_d;
	logic [AW-1:0] res_last_q, res_last_d;
	logic [CW-1:0] res_count_q, res_count_d;

	// probe step temporaries
	logic signed [PW-1:0] range_lo, range_hi;
	logic signed [PW-1:0] mid_ext;
	logic signed [PW-1:0] nlo, nhi, bound_sum, start_sum;
	logic                 hit_n;
	logic [AW-1:0]        hit_pos_n;
	logic                 answer_ok;

	logic load_accept;
	logic query_accept;

	// input is open only while the sequencer is idle
	assign query_stall = (state_q != sters_pkg::ST_IDLE);

	assign query_accept = query_valid && !query_stall && (operation == sters_pkg::OP_QUERY);
	assign load_accept  = query_valid && !query_stall && (operation == sters_pkg::OP_LOAD);

	// range_last can never exceed the top of the table, so no clamp is needed
	assign range_lo = PW'(range_first_q);
	assign range_hi = PW'(range_last_q);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_first_q <= '0;
			range_last_q  <= AW'(sters_pkg::TABLE_DEPTH - 1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sters_pkg::REG_RANGE_FIRST: range_first_q <= cfg_data;
				sters_pkg::REG_RANGE_LAST:  range_last_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// table write on load, read of the probe address every cycle
	always_ff @(posedge clk) begin
		if (load_accept) begin
			table_mem[entry_index] <= entry_value;
		end
		rd_data_q <= table_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sters_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
		end
	end

	// datapath and result payload, no reset needed
	always_ff @(posedge clk) begin
		key_q        <= key_d;
		lo_q         <= lo_d;
		hi_q         <= hi_d;
		mid_q        <= mid_d;
		seek_right_q <= seek_right_d;
		hit_q        <= hit_d;
		hit_pos_q    <= hit_pos_d;
		first_ok_q   <= first_ok_d;
		first_pos_q  <= first_pos_d;
		res_found_q  <= res_found_d;
		res_first_q  <= res_first_d;
		res_last_q   <= res_last_d;
		res_count_q  <= res_count_d;
	end

	always_comb begin
		state_d      = state_q;
		key_d        = key_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		mid_d        = mid_q;
		seek_right_d = seek_right_q;
		hit_d        = hit_q;
		hit_pos_d    = hit_pos_q;
		first_ok_d   = first_ok_q;
		first_pos_d  = first_pos_q;
		res_valid_d  = res_valid_q && result_stall;
		res_found_d  = res_found_q;
		res_first_d  = res_first_q;
		res_last_d   = res_last_q;
		res_count_d  = res_count_q;

		// midpoint of the current bounds, valid only while lo <= hi (both in the table)
		start_sum = lo_q + hi_q;
		rd_addr   = start_sum[AW:1];

		// one probe: compare the entry read at mid against the key and narrow the bounds
		mid_ext   = PW'(mid_q);
		nlo       = lo_q;
		nhi       = hi_q;
		hit_n     = hit_q;
		hit_pos_n = hit_pos_q;
		if (rd_data_q < key_q) begin
			nlo = mid_ext + PW'(1);
		end else if (rd_data_q > key_q) begin
			nhi = mid_ext - PW'(1);
		end else begin
			hit_n     = 1'b1;
			hit_pos_n = mid_q;
			if (seek_right_q) begin
				nlo = mid_ext + PW'(1);
			end else begin
				nhi = mid_ext - PW'(1);
			end
		end
		bound_sum = nlo + nhi;

		// rightmost must not lie below leftmost, or the table was not sorted
		answer_ok = first_ok_q && hit_q && (hit_pos_q >= first_pos_q);

		unique case (state_q)
			sters_pkg::ST_IDLE: begin
				if (query_accept) begin
					key_d        = search_key;
					lo_d         = range_lo;
					hi_d         = range_hi;
					seek_right_d = 1'b0;
					hit_d        = 1'b0;
					state_d      = sters_pkg::ST_START;
				end
			end
			sters_pkg::ST_START: begin
				if (lo_q <= hi_q) begin
					// first probe address goes to the memory now
					mid_d   = rd_addr;
					state_d = sters_pkg::ST_PROBE;
				end else if (!seek_right_q) begin
					// empty window: both searches come out empty
					first_ok_d   = 1'b0;
					seek_right_d = 1'b1;
					hit_d        = 1'b0;
				end else begin
					state_d = sters_pkg::ST_DONE;
				end
			end
			sters_pkg::ST_PROBE: begin
				hit_d     = hit_n;
				hit_pos_d = hit_pos_n;
				if (nlo <= nhi) begin
					// keep going, next address straight from the new bounds
					lo_d    = nlo;
					hi_d    = nhi;
					rd_addr = bound_sum[AW:1];
					mid_d   = bound_sum[AW:1];
				end else if (!seek_right_q) begin
					// leftmost search over, restart on the full window for the rightmost
					first_ok_d   = hit_n;
					first_pos_d  = hit_pos_n;
					seek_right_d = 1'b1;
					hit_d        = 1'b0;
					lo_d         = range_lo;
					hi_d         = range_hi;
					state_d      = sters_pkg::ST_START;
				end else begin
					state_d = sters_pkg::ST_DONE;
				end
			end
			sters_pkg::ST_DONE: begin
				// wait here only while an earlier result is still held
				if (!res_valid_q || !result_stall) begin
					res_valid_d = 1'b1;
					res_found_d = answer_ok;
					res_first_d = answer_ok ? first_pos_q : '0;
					res_last_d  = answer_ok ? hit_pos_q : '0;
					res_count_d = answer_ok
						? CW'({1'b0, hit_pos_q} - {1'b0, first_pos_q} + CW'(1)) : '0;
					state_d     = sters_pkg::ST_IDLE;
				end
			end
			default: state_d = sters_pkg::ST_IDLE;
		endcase
	end

	assign result_valid   = res_valid_q;
	assign found          = res_found_q;
	assign first_position = res_first_q;
	assign last_position  = res_last_q;
	assign match_count    = res_count_q;

endmodule

// ----- hdl/sters_checker.sv -----
`timescale 1ns / 1ps

`include "sorted_table_equal_range_search_unit_assert.svh"

module sters_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               query_valid,
	input logic                               query_stall,
	input logic                               operation,
	input logic                               result_valid,
	input logic                               result_stall,
	input logic                               found,
	input logic [sters_pkg::ADDR_W-1:0]       first_position,
	input logic [sters_pkg::ADDR_W-1:0]       last_position,
	input logic [sters_pkg::CNT_W-1:0]        match_count
);

	logic query_taken;
	logic [sters_pkg::CNT_W-1:0] span;

	assign query_taken = query_valid && !query_stall && (operation == sters_pkg::OP_QUERY);
	assign span = sters_pkg::CNT_W'({1'b0, last_position} - {1'b0, first_position}
		+ sters_pkg::CNT_W'(1));

	// a held result stays valid and keeps found, match_count and first_position
	`STERS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall,
		result_valid && $stable(found) && $stable(match_count) && $stable(first_position),
		"result changed while stalled")

	// a query keeps the input stalled while it searches
	`STERS_ASSERT_NEXT(a_busy_after_query, clk, arst_n, query_taken, query_stall,
		"input not stalled after query")

	// a miss reports all zero
	`STERS_ASSERT_NOW(a_miss_zero, clk, arst_n, result_valid && !found,
		first_position == '0 && last_position == '0 && match_count == '0,
		"nonzero fields on a miss")

	// a hit spans a non-empty ordered range
	`STERS_ASSERT_NOW(a_hit_span, clk, arst_n, result_valid && found,
		last_position >= first_position && match_count == span,
		"inconsistent hit range")

endmodule

bind sorted_table_equal_range_search_unit sters_checker u_sters_checker (.*);
